// File: design/wpl_pkg.sv
// Shared types and constants for the wheel power limiter.
`default_nettype none

package wpl_pkg;

    localparam int WHEELS    = 4;
    localparam int SPD_W     = 16;
    localparam int BUDGET_W  = 22;
    localparam int GAIN_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int RATIO_W   = FRAC_W + 1;
    localparam int SCALE_W   = 12;
    localparam int BM_W      = BUDGET_W + SCALE_W;
    localparam int BUDGET_SH = 10;
    localparam int LO_W      = 18;
    localparam int ACC_W     = 52;
    localparam int DIV_W     = 48;
    localparam int PROD_W    = SPD_W + 1 + RATIO_W;

    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd256;
    // 3200000 = 3125 << 10
    localparam logic [SCALE_W-1:0] BUDGET_SCALE = 12'd3125;
    localparam logic [RATIO_W-1:0] RATIO_ONE    = 17'h10000;

    typedef logic [WHEELS-1:0][SPD_W-1:0] speed_vec_t;

    // One wheel set after classification, waiting for the divide and scale.
    typedef struct packed {
        speed_vec_t       target;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic             div_en;
        logic             ratio_one;
        logic             limited;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: design/wpl_front.sv
// Front pipeline: power estimate, budget compare and request classification.
`default_nettype none

module wpl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  wpl_pkg::speed_vec_t           target,
    input  wpl_pkg::speed_vec_t           measured,
    input  logic [wpl_pkg::BUDGET_W-1:0]  budget,
    input  logic [wpl_pkg::GAIN_W-1:0]    gain,
    input  wpl_pkg::q_status_t            q_status,
    output logic                          push,
    output wpl_pkg::job_t                 push_job
);
    import wpl_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic              front_en;

    // stage 1
    logic signed [SPD_W:0]     diff      [WHEELS];
    logic signed [2*SPD_W:0]   d_next    [WHEELS];
    logic signed [2*SPD_W-1:0] p_next    [WHEELS];
    logic [BM_W-1:0]           bm_next;
    speed_vec_t                t1_reg;
    logic signed [2*SPD_W:0]   d1_reg    [WHEELS];
    logic signed [2*SPD_W-1:0] p1_reg    [WHEELS];
    logic [BM_W-1:0]           bm1_reg;

    // stage 2
    logic [2*SPD_W+2:0]        s1_next;
    logic [2*SPD_W+1:0]        s2_next;
    speed_vec_t                t2_reg;
    logic [2*SPD_W+2:0]        s1_reg;
    logic [2*SPD_W+1:0]        s2_reg;
    logic [BM_W-1:0]           bm2_reg;

    // stage 3
    logic signed [GAIN_W:0]    gain_s;
    logic [GAIN_W+LO_W-1:0]    m1lo_next;
    logic signed [33:0]        m1hi_next;
    logic [GAIN_W+LO_W-1:0]    m2lo_next;
    logic signed [32:0]        m2hi_next;
    speed_vec_t                t3_reg;
    logic [GAIN_W+LO_W-1:0]    m1lo_reg;
    logic signed [33:0]        m1hi_reg;
    logic [GAIN_W+LO_W-1:0]    m2lo_reg;
    logic signed [32:0]        m2hi_reg;
    logic [BM_W-1:0]           bm3_reg;

    // stage 4
    logic signed [ACC_W-1:0]   gs1_next;
    logic signed [ACC_W-1:0]   gs2_next;
    speed_vec_t                t4_reg;
    logic signed [ACC_W-1:0]   gs1_reg;
    logic signed [ACC_W-1:0]   gs2_reg;
    logic [BM_W-1:0]           bm4_reg;

    // stage 5
    logic signed [ACC_W-1:0]   num_next;
    speed_vec_t                t5_reg;
    logic signed [ACC_W-1:0]   num_reg;
    logic signed [ACC_W-1:0]   den_reg;

    // stage 6
    logic                      limited;
    logic                      den_neg;
    logic                      den_zero;
    logic                      num_lt_den;
    logic [ACC_W-1:0]          excess_gap;
    job_t                      job_next;
    job_t                      job_reg;

    // Hold the whole front while its last stage waits on a full queue.
    assign front_en = !vld_reg[STAGES-1] || !q_status.full;
    assign s_ready  = front_en;
    assign push     = vld_reg[STAGES-1] && !q_status.full;
    assign push_job = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (front_en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            diff[k]   = $signed({target[k][SPD_W-1], target[k]})
                      - $signed({measured[k][SPD_W-1], measured[k]});
            d_next[k] = (2*SPD_W+1)'(diff[k]) * (2*SPD_W+1)'($signed(measured[k]));
            p_next[k] = (2*SPD_W)'($signed(target[k])) * (2*SPD_W)'($signed(measured[k]));
        end
        bm_next = BM_W'(budget) * BM_W'(BUDGET_SCALE);
    end

    always_comb begin
        s1_next = '0;
        s2_next = '0;
        for (int k = 0; k < WHEELS; k++) begin
            s1_next = s1_next + {{2{d1_reg[k][2*SPD_W]}}, d1_reg[k]};
            s2_next = s2_next + {{2{p1_reg[k][2*SPD_W-1]}}, p1_reg[k]};
        end
    end

    // Split both sums so each gain product stays near 17 x 18 bits.
    assign gain_s    = $signed({1'b0, gain});
    assign m1lo_next = (GAIN_W+LO_W)'(gain) * (GAIN_W+LO_W)'(s1_reg[LO_W-1:0]);
    assign m1hi_next = 34'(gain_s) * 34'($signed(s1_reg[2*SPD_W+2:LO_W]));
    assign m2lo_next = (GAIN_W+LO_W)'(gain) * (GAIN_W+LO_W)'(s2_reg[LO_W-1:0]);
    assign m2hi_next = 33'(gain_s) * 33'($signed(s2_reg[2*SPD_W+1:LO_W]));

    assign gs1_next = $signed({m1hi_reg, {LO_W{1'b0}}})
                    + $signed(ACC_W'(m1lo_reg));
    assign gs2_next = $signed({m2hi_reg[32], m2hi_reg, {LO_W{1'b0}}})
                    + $signed(ACC_W'(m2lo_reg));

    assign num_next = gs1_reg - $signed(ACC_W'({bm4_reg, {BUDGET_SH{1'b0}}}));

    always_comb begin
        limited    = !num_reg[ACC_W-1] && (num_reg != '0);
        den_neg    = den_reg[ACC_W-1];
        den_zero   = (den_reg == '0);
        num_lt_den = (num_reg < den_reg);
        excess_gap = den_reg - num_reg;

        job_next.target    = t5_reg;
        job_next.rem       = excess_gap[DIV_W-1:0];
        job_next.den       = den_reg[DIV_W-1:0];
        job_next.div_en    = limited && !den_neg && !den_zero && num_lt_den;
        job_next.ratio_one = !limited || den_neg;
        job_next.limited   = limited;
    end

    always_ff @(posedge aclk) begin
        if (front_en) begin
            t1_reg  <= target;
            d1_reg  <= d_next;
            p1_reg  <= p_next;
            bm1_reg <= bm_next;

            t2_reg  <= t1_reg;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            bm2_reg <= bm1_reg;

            t3_reg   <= t2_reg;
            m1lo_reg <= m1lo_next;
            m1hi_reg <= m1hi_next;
            m2lo_reg <= m2lo_next;
            m2hi_reg <= m2hi_next;
            bm3_reg  <= bm2_reg;

            t4_reg  <= t3_reg;
            gs1_reg <= gs1_next;
            gs2_reg <= gs2_next;
            bm4_reg <= bm3_reg;

            t5_reg  <= t4_reg;
            num_reg <= num_next;
            den_reg <= gs2_reg;

            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

// File: design/wpl_queue.sv
// Short request queue between the front and back pipelines.
`default_nettype none

module wpl_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  wpl_pkg::job_t      push_job,
    input  logic               pop,
    output wpl_pkg::job_t      head,
    output wpl_pkg::q_status_t status
);
    import wpl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: design/wpl_back.sv
// Back pipeline: restoring ratio divide, one bit per stage, then target scaling.
`default_nettype none

module wpl_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wpl_pkg::q_status_t           q_status,
    input  wpl_pkg::job_t                head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output wpl_pkg::speed_vec_t          limited,
    output logic [wpl_pkg::RATIO_W-1:0]  ratio,
    output logic                         was_limited
);
    import wpl_pkg::*;

    localparam int NSTEP = FRAC_W;

    logic                back_en;

    job_t                dv_job_reg [NSTEP];
    logic [FRAC_W-1:0]   dv_q_reg   [NSTEP];
    logic [NSTEP-1:0]    dv_vld_reg;

    logic [RATIO_W-1:0]  ratio_sel;
    logic [SPD_W:0]      mag        [WHEELS];
    logic [PROD_W-1:0]   prod_next  [WHEELS];
    logic [PROD_W-1:0]   mu_prod_reg[WHEELS];
    logic [WHEELS-1:0]   mu_neg_reg;
    logic [RATIO_W-1:0]  mu_ratio_reg;
    logic                mu_lim_reg;
    logic                mu_vld_reg;

    logic [SPD_W:0]      scaled     [WHEELS];
    speed_vec_t          res_next;
    speed_vec_t          out_spd_reg;
    logic [RATIO_W-1:0]  out_ratio_reg;
    logic                out_lim_reg;
    logic                out_vld_reg;

    // Advance the whole back end whenever the output register can move.
    assign back_en     = !out_vld_reg || m_ready;
    assign pop         = back_en && !q_status.empty;
    assign m_valid     = out_vld_reg;
    assign limited     = out_spd_reg;
    assign ratio       = out_ratio_reg;
    assign was_limited = out_lim_reg;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        job_t              src;
        logic [FRAC_W-1:0] q_in;
        logic [DIV_W:0]    shifted;
        logic [DIV_W:0]    trial;
        logic              take;
        job_t              job_next;
        logic [FRAC_W-1:0] q_next;

        if (k == 0) begin : g_first
            assign src  = head;
            assign q_in = '0;
        end else begin : g_rest
            assign src  = dv_job_reg[k-1];
            assign q_in = dv_q_reg[k-1];
        end

        always_comb begin
            shifted      = {src.rem, 1'b0};
            trial        = shifted - {1'b0, src.den};
            take         = (shifted >= {1'b0, src.den});
            job_next     = src;
            job_next.rem = take ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            q_next       = {q_in[FRAC_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (back_en) begin
                dv_job_reg[k] <= job_next;
                dv_q_reg[k]   <= q_next;
            end
        end
    end

    always_comb begin
        priority if (dv_job_reg[NSTEP-1].div_en) begin
            ratio_sel = {1'b0, dv_q_reg[NSTEP-1]};
        end else if (dv_job_reg[NSTEP-1].ratio_one) begin
            ratio_sel = RATIO_ONE;
        end else begin
            ratio_sel = '0;
        end
        for (int k = 0; k < WHEELS; k++) begin
            mag[k] = dv_job_reg[NSTEP-1].target[k][SPD_W-1]
                   ? -{dv_job_reg[NSTEP-1].target[k][SPD_W-1], dv_job_reg[NSTEP-1].target[k]}
                   : {1'b0, dv_job_reg[NSTEP-1].target[k]};
            prod_next[k] = PROD_W'(mag[k]) * PROD_W'(ratio_sel);
        end
    end

    // Drop the fraction and restore the sign; magnitude never grows.
    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            scaled[k]   = mu_prod_reg[k][FRAC_W +: SPD_W+1];
            scaled[k]   = mu_neg_reg[k] ? -scaled[k] : scaled[k];
            res_next[k] = scaled[k][SPD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            for (int k = 0; k < WHEELS; k++) begin
                mu_prod_reg[k] <= prod_next[k];
                mu_neg_reg[k]  <= dv_job_reg[NSTEP-1].target[k][SPD_W-1];
            end
            mu_ratio_reg  <= ratio_sel;
            mu_lim_reg    <= dv_job_reg[NSTEP-1].limited;

            out_spd_reg   <= res_next;
            out_ratio_reg <= mu_ratio_reg;
            out_lim_reg   <= mu_lim_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg  <= '0;
            mu_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (back_en) begin
            dv_vld_reg  <= {dv_vld_reg[NSTEP-2:0], !q_status.empty};
            mu_vld_reg  <= dv_vld_reg[NSTEP-1];
            out_vld_reg <= mu_vld_reg;
        end
    end

endmodule

`default_nettype wire

// File: design/wheel_power_limiter_unit.sv
// Top level of the wheel power limiter: gain register, front, queue and back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | 4 targets, 4 measured speeds, budget
//  m_      | out       | m_valid / m_ready  | 4 limited targets, scale ratio, flag
//  cfg_    | in        | cfg_wr_en          | speed gain, Q8.8
//
// One request per cycle is accepted and one result per cycle leaves when m_ready stays high.
// A request passes through 6 front stages, one queue slot, 16 divide
// stages (one quotient bit each), one multiply stage and the output register.
// Reset clears all valid bits and the queue pointers and sets the gain to 1.0.
// A stalled output holds the back end; the front keeps accepting until the queue fills.
`default_nettype none

module wheel_power_limiter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [wpl_pkg::GAIN_W-1:0]            cfg_wr_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_target_front_left,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_target_front_right,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_target_back_left,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_target_back_right,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_measured_front_left,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_measured_front_right,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_measured_back_left,
    input  logic signed [wpl_pkg::SPD_W-1:0]      s_measured_back_right,
    input  logic [wpl_pkg::BUDGET_W-1:0]          s_power_budget,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [wpl_pkg::SPD_W-1:0]      m_limited_front_left,
    output logic signed [wpl_pkg::SPD_W-1:0]      m_limited_front_right,
    output logic signed [wpl_pkg::SPD_W-1:0]      m_limited_back_left,
    output logic signed [wpl_pkg::SPD_W-1:0]      m_limited_back_right,
    output logic [wpl_pkg::RATIO_W-1:0]           m_scale_ratio,
    output logic                                  m_was_limited
);
    import wpl_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    speed_vec_t        target;
    speed_vec_t        measured;
    speed_vec_t        limited;
    q_status_t         q_status;
    job_t              push_job;
    job_t              head;
    logic              push;
    logic              pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    assign target[0]   = s_target_front_left;
    assign target[1]   = s_target_front_right;
    assign target[2]   = s_target_back_left;
    assign target[3]   = s_target_back_right;
    assign measured[0] = s_measured_front_left;
    assign measured[1] = s_measured_front_right;
    assign measured[2] = s_measured_back_left;
    assign measured[3] = s_measured_back_right;

    assign m_limited_front_left  = limited[0];
    assign m_limited_front_right = limited[1];
    assign m_limited_back_left   = limited[2];
    assign m_limited_back_right  = limited[3];

    wpl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .target   (target),
        .measured (measured),
        .budget   (s_power_budget),
        .gain     (gain_reg),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    wpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    wpl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .limited     (limited),
        .ratio       (m_scale_ratio),
        .was_limited (m_was_limited)
    );

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_status.full))
        else $error("front pushed into a full queue");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_scale_ratio <= RATIO_ONE))
        else $error("scale ratio above one");

    a_unlimited_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_was_limited) |-> (m_scale_ratio == RATIO_ONE))
        else $error("unlimited result with a ratio other than one");

    a_zero_ratio_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_scale_ratio == '0)) |->
            ((m_limited_front_left == '0) && (m_limited_front_right == '0) &&
             (m_limited_back_left == '0) && (m_limited_back_right == '0)))
        else $error("zero ratio left a nonzero target");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for the wheel power limiter: directed table, random wheel sets, scoreboard.
`default_nettype none

module tb_top;

    typedef struct packed {
        wpl_pkg::speed_vec_t              tgt;
        wpl_pkg::speed_vec_t              meas;
        logic [wpl_pkg::BUDGET_W-1:0]     budget;
    } wheel_req_t;

    typedef struct packed {
        wpl_pkg::speed_vec_t              lim;
        logic [wpl_pkg::RATIO_W-1:0]      ratio;
        logic                             limited;
    } wheel_res_t;

    typedef struct packed {
        logic [wpl_pkg::GAIN_W-1:0]       gain;
        wheel_req_t                       req;
        logic                             has_value;
        wheel_res_t                       res;
    } dir_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_BURSTY,
        READY_SPARSE
    } sink_mode_t;

    // 3200000 turns budget in 1/16 W into the gain * speed product scale
    localparam longint POWER_SCALE  = 64'd3200000;
    localparam int     PHASE_COUNT  = 6;
    localparam int     PHASE_ITEMS  = 210;
    localparam int     DRAIN_CYCLES = 40;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                             cfg_wr_en   = 1'b0;
    logic [wpl_pkg::GAIN_W-1:0]       cfg_wr_data = '0;

    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [wpl_pkg::SPD_W-1:0] s_target_front_left    = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_target_front_right   = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_target_back_left     = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_target_back_right    = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_measured_front_left  = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_measured_front_right = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_measured_back_left   = '0;
    logic signed [wpl_pkg::SPD_W-1:0] s_measured_back_right  = '0;
    logic [wpl_pkg::BUDGET_W-1:0]     s_power_budget         = '0;

    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [wpl_pkg::SPD_W-1:0] m_limited_front_left;
    logic signed [wpl_pkg::SPD_W-1:0] m_limited_front_right;
    logic signed [wpl_pkg::SPD_W-1:0] m_limited_back_left;
    logic signed [wpl_pkg::SPD_W-1:0] m_limited_back_right;
    logic [wpl_pkg::RATIO_W-1:0]      m_scale_ratio;
    logic                             m_was_limited;

    logic [wpl_pkg::GAIN_W-1:0]       gain_now = wpl_pkg::GAIN_RESET;
    wheel_res_t                       pending_limits [$];
    dir_row_t                         dir_table [$];
    int                               mismatches  = 0;
    int                               burst_left  = 0;
    bit                               sender_gaps = 1'b1;
    sink_mode_t                       sink_mode   = READY_RANDOM;
    logic [7:0]                       tick        = '0;
    string wheel_name [4] = '{"limited_front_left", "limited_front_right",
                              "limited_back_left", "limited_back_right"};

    wheel_power_limiter_unit DUT (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_wr_data            (cfg_wr_data),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_target_front_left    (s_target_front_left),
        .s_target_front_right   (s_target_front_right),
        .s_target_back_left     (s_target_back_left),
        .s_target_back_right    (s_target_back_right),
        .s_measured_front_left  (s_measured_front_left),
        .s_measured_front_right (s_measured_front_right),
        .s_measured_back_left   (s_measured_back_left),
        .s_measured_back_right  (s_measured_back_right),
        .s_power_budget         (s_power_budget),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_limited_front_left   (m_limited_front_left),
        .m_limited_front_right  (m_limited_front_right),
        .m_limited_back_left    (m_limited_back_left),
        .m_limited_back_right   (m_limited_back_right),
        .m_scale_ratio          (m_scale_ratio),
        .m_was_limited          (m_was_limited)
    );

    always #6 aclk = ~aclk;

    // Index 0..3 is front left, front right, back left, back right throughout.
    function automatic wheel_req_t mk_req(int t0, int t1, int t2, int t3,
                                          int m0, int m1, int m2, int m3, int b);
        wheel_req_t rq;
        rq.tgt[0]  = 16'(t0);
        rq.tgt[1]  = 16'(t1);
        rq.tgt[2]  = 16'(t2);
        rq.tgt[3]  = 16'(t3);
        rq.meas[0] = 16'(m0);
        rq.meas[1] = 16'(m1);
        rq.meas[2] = 16'(m2);
        rq.meas[3] = 16'(m3);
        rq.budget  = 22'(b);
        return rq;
    endfunction

    function automatic wheel_res_t mk_res(int l0, int l1, int l2, int l3, int r, int f);
        wheel_res_t rs;
        rs.lim[0]  = 16'(l0);
        rs.lim[1]  = 16'(l1);
        rs.lim[2]  = 16'(l2);
        rs.lim[3]  = 16'(l3);
        rs.ratio   = 17'(r);
        rs.limited = f[0];
        return rs;
    endfunction

    function automatic dir_row_t row(logic [15:0] g, wheel_req_t rq, logic has_value,
                                     wheel_res_t rs);
        dir_row_t r;
        r.gain      = g;
        r.req       = rq;
        r.has_value = has_value;
        r.res       = rs;
        return r;
    endfunction

    // Power estimate against budget, then a common Q1.16 ratio on all four targets.
    function automatic wheel_res_t limit_wheels(wheel_req_t rq, logic [15:0] g16);
        wheel_res_t  rs;
        longint      t, m, g, s_diff, s_prod, excess, denom, mag, p;
        logic [95:0] wide_num, wide_den;
        s_diff = 0;
        s_prod = 0;
        for (int i = 0; i < 4; i++) begin
            t = longint'($signed(rq.tgt[i]));
            m = longint'($signed(rq.meas[i]));
            s_diff += (t - m) * m;
            s_prod += t * m;
        end
        g      = longint'(g16);
        excess = g * s_diff - POWER_SCALE * longint'(rq.budget);
        rs.lim     = rq.tgt;
        rs.ratio   = wpl_pkg::RATIO_ONE;
        rs.limited = 1'b0;
        if (excess > 0) begin
            rs.limited = 1'b1;
            denom = g * s_prod;
            if (denom == 0) begin
                rs.ratio = '0;
            end else if (denom < 0) begin
                rs.ratio = wpl_pkg::RATIO_ONE;
            end else if (excess >= denom) begin
                rs.ratio = '0;
            end else begin
                wide_num = denom - excess;
                wide_den = denom;
                wide_num = (wide_num << 16) / wide_den;
                rs.ratio = wide_num[16:0];
            end
            // scale the magnitude, truncate toward zero
            for (int i = 0; i < 4; i++) begin
                t   = longint'($signed(rq.tgt[i]));
                mag = (t < 0) ? -t : t;
                p   = (mag * longint'(rs.ratio)) >>> 16;
                rs.lim[i] = 16'((t < 0) ? -p : p);
            end
        end
        return rs;
    endfunction

    function automatic wheel_req_t random_wheel_set();
        wheel_req_t rq;
        int         shape, k;
        shape = $urandom_range(0, 9);
        k     = $urandom_range(0, 8);
        for (int i = 0; i < 4; i++) begin
            rq.tgt[i] = 16'($urandom);
            if (shape <= 2) begin
                rq.meas[i] = 16'($urandom);
            end else if (shape <= 6) begin
                // measured speed trails the target, same sign, a little noise
                rq.meas[i] = 16'(($signed(rq.tgt[i]) * k) / 8
                                 + int'($urandom_range(0, 64)) - 32);
            end else if (shape <= 8) begin
                rq.tgt[i]  = 16'(int'($urandom_range(0, 4000)) - 2000);
                rq.meas[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
            end else begin
                rq.meas[i] = $urandom_range(0, 1) ? '0 : rq.tgt[i];
            end
        end
        case ($urandom_range(0, 4))
            0: rq.budget = '0;
            1: rq.budget = 22'($urandom_range(0, 1023));
            2: rq.budget = 22'($urandom_range(0, 65535));
            3: rq.budget = 22'($urandom_range(0, 1 << 20));
            default: rq.budget = 22'($urandom);
        endcase
        return rq;
    endfunction

    task automatic send_request(input wheel_req_t rq, input logic has_value,
                                input wheel_res_t given);
        if (sender_gaps && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        s_valid                <= 1'b1;
        s_target_front_left    <= rq.tgt[0];
        s_target_front_right   <= rq.tgt[1];
        s_target_back_left     <= rq.tgt[2];
        s_target_back_right    <= rq.tgt[3];
        s_measured_front_left  <= rq.meas[0];
        s_measured_front_right <= rq.meas[1];
        s_measured_back_left   <= rq.meas[2];
        s_measured_back_right  <= rq.meas[3];
        s_power_budget         <= rq.budget;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_limits.push_back(has_value ? given : limit_wheels(rq, gain_now));
    endtask

    // Drain the pipeline before touching the gain.
    task automatic load_gain(input logic [15:0] g);
        s_valid <= 1'b0;
        while (pending_limits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_now = g;
    endtask

    always @(posedge aclk) begin
        tick <= tick + 8'd1;
        case (sink_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_RANDOM: m_ready <= ($urandom_range(0, 99) >= 30);
            READY_BURSTY: m_ready <= (tick[5:0] < 6'd40);
            default:      m_ready <= (tick % 3 == 0);
        endcase
    end

    always @(posedge aclk) begin
        wheel_res_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got.lim[0]  = m_limited_front_left;
            got.lim[1]  = m_limited_front_right;
            got.lim[2]  = m_limited_back_left;
            got.lim[3]  = m_limited_back_right;
            got.ratio   = m_scale_ratio;
            got.limited = m_was_limited;
            if (pending_limits.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                mismatches++;
            end else begin
                want = pending_limits.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.lim[i] !== want.lim[i]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, wheel_name[i],
                                 $signed(want.lim[i]), $signed(got.lim[i]));
                        mismatches++;
                    end
                end
                if (got.ratio !== want.ratio) begin
                    $display("%0t: scale_ratio expected %0d actual %0d",
                             $time, want.ratio, got.ratio);
                    mismatches++;
                end
                if (got.limited !== want.limited) begin
                    $display("%0t: was_limited expected %0d actual %0d",
                             $time, want.limited, got.limited);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [15:0] phase_gain [PHASE_COUNT];
        wheel_res_t  none;
        none = '0;
        phase_gain = '{16'd1, 16'hFFFF, wpl_pkg::GAIN_RESET, 16'($urandom_range(2, 65534)),
                       16'd0, 16'($urandom_range(2, 65534))};

        // gain at reset value: pass-through at zero and extreme speeds
        dir_table.push_back(row(16'd256, mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                mk_res(0, 0, 0, 0, 65536, 0)));
        dir_table.push_back(row(16'd256,
            mk_req(32767, 32767, 32767, 32767, 0, 0, 0, 0, 4194303), 1'b1,
            mk_res(32767, 32767, 32767, 32767, 65536, 0)));
        dir_table.push_back(row(16'd256,
            mk_req(-32768, -32768, -32768, -32768, 0, 0, 0, 0, 0), 1'b1,
            mk_res(-32768, -32768, -32768, -32768, 65536, 0)));
        dir_table.push_back(row(16'd256,
            mk_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0), 1'b1,
            mk_res(-32768, -32768, -32768, -32768, 65536, 0)));
        dir_table.push_back(row(16'd256,
            mk_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 0), 1'b1,
            mk_res(-32768, -32768, -32768, -32768, 65536, 0)));
        // one wheel barely moving: ratio drops to almost zero
        dir_table.push_back(row(16'd256, mk_req(32767, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1,
                                mk_res(0, 0, 0, 0, 2, 1)));
        // estimate exactly at the budget, then one step over
        dir_table.push_back(row(16'd256, mk_req(225, 0, 0, 0, 100, 0, 0, 0, 1), 1'b1,
                                mk_res(225, 0, 0, 0, 65536, 0)));
        dir_table.push_back(row(16'd256, mk_req(226, 0, 0, 0, 100, 0, 0, 0, 1), 1'b0, none));
        // opposing target and speed: negative product, never over budget
        dir_table.push_back(row(16'd256, mk_req(-100, 0, 0, 0, 100, 0, 0, 0, 0), 1'b1,
                                mk_res(-100, 0, 0, 0, 65536, 0)));
        dir_table.push_back(row(16'd256,
            mk_req(-32768, -32768, -32768, -32768, -32767, -32767, -32767, -32767, 0),
            1'b0, none));
        dir_table.push_back(row(16'd256,
            mk_req(1000, -1000, 2000, -2000, 500, -500, 1000, -1000, 5), 1'b0, none));
        dir_table.push_back(row(16'd256,
            mk_req(32767, 32767, 32767, 32767, 20000, 20000, 20000, 20000, 4194303),
            1'b0, none));
        // zero gain: estimate is zero, nothing is limited
        dir_table.push_back(row(16'd0,
            mk_req(32767, 32767, 32767, 32767, 1, 1, 1, 1, 0), 1'b1,
            mk_res(32767, 32767, 32767, 32767, 65536, 0)));
        dir_table.push_back(row(16'd0,
            mk_req(-32768, -32768, -32768, -32768, -32767, -32767, -32767, -32767, 0), 1'b1,
            mk_res(-32768, -32768, -32768, -32768, 65536, 0)));
        // largest gain
        dir_table.push_back(row(16'hFFFF,
            mk_req(-32768, -32768, -32768, -32768, -32767, -32767, -32767, -32767, 0),
            1'b0, none));
        dir_table.push_back(row(16'hFFFF,
            mk_req(32767, 32767, 32767, 32767, 16384, 16384, 16384, 16384, 4194303),
            1'b0, none));
        dir_table.push_back(row(16'hFFFF,
            mk_req(1000, -1000, 2000, -2000, 500, -500, 1000, -1000, 3), 1'b0, none));
        dir_table.push_back(row(16'hFFFF,
            mk_req(32767, 32767, 32767, 32767, 1, 1, 1, 1, 4194303), 1'b0, none));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].gain != gain_now) load_gain(dir_table[i].gain);
            send_request(dir_table[i].req, dir_table[i].has_value, dir_table[i].res);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            load_gain(phase_gain[ph]);
            sink_mode   = sink_mode_t'(ph % 4);
            sender_gaps = (ph != 1 && ph != 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_wheel_set(), 1'b0, none);
            end
        end

        s_valid <= 1'b0;
        while (pending_limits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
